// File: rtl/core/trfr_pkg.sv
// Shared types and constants for the task ready queue with remove.
package trfr_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int ID_W          = 5;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Per-cell control from the queue controller.
  typedef struct packed {
    logic occupied;  // slot index below the entry count
    logic at_tail;   // slot index equals the entry count
    logic append;    // enqueue into a non-full queue this cycle
    logic collapse;  // dequeue or remove may close a gap this cycle
  } cell_ctrl_t;

endpackage

// File: rtl/core/trfr_cell.sv
// One queue slot: holds an identifier, matches the key and shifts down on collapse.
module trfr_cell
  import trfr_pkg::*;
(
  input  logic            clk,
  input  cell_ctrl_t      ctrl,
  input  logic [ID_W-1:0] key,
  input  logic [ID_W-1:0] upper_id,
  input  logic            hit_in,
  output logic            hit_out,
  output logic [ID_W-1:0] id
);

  logic match;

  assign match   = ctrl.occupied && (id == key);
  assign hit_out = hit_in || match;

  always_ff @(posedge clk) begin
    if (ctrl.collapse && hit_out) begin
      // take the neighbor above: closes the gap at or below this slot
      id <= upper_id;
    end else if (ctrl.append && ctrl.at_tail) begin
      id <= key;
    end
  end

endmodule

// File: rtl/core/task_ready_fifo_with_remove_unit.sv
// Top level of the task ready queue: cell row, entry count and output register.
//
//   channel | dir | tdata               | tuser
//   s_*     | in  | [4:0] task_id       | [1:0] opcode
//   m_*     | out | [4:0] out_task_id   | [1:0] status
//
// Each result is registered and offered in the cycle after its word is taken;
// one word per cycle is sustained while the output is drained. The match
// in the cell row is combinational, its first-match flag rippling from the head cell to the tail cell.
// Reset clears the entry count and the output valid; slot contents are not
// cleared, since only slots below the count are ever read.
// A result waits in the output register; a new word is taken whenever that
// register is empty or is being drained in the same cycle.
module task_ready_fifo_with_remove_unit
  import trfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [4:0] task_id, [7:5] zero
  input  logic [1:0] s_tuser,   // [1:0] opcode
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [4:0] out_task_id, [7:5] zero
  output logic [1:0] m_tuser    // [1:0] status
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count, count_next;
  logic [ID_W-1:0]  res_id, res_id_next;
  status_t          status, status_next;
  logic             s_fire;
  logic [ID_W-1:0]  key;
  op_t              op;
  logic             is_full, is_empty;
  logic             append, collapse, deq_hit;

  logic [ID_W-1:0]        cell_id [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   hit;
  cell_ctrl_t             cell_ctrl [QUEUE_DEPTH];

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign key      = s_tdata[ID_W-1:0];
  assign op       = op_t'(s_tuser);
  assign is_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count == '0);

  assign append   = s_fire && (op == OP_ENQ) && !is_full;
  assign collapse = s_fire && (((op == OP_DEQ) && !is_empty) || (op == OP_REMOVE));
  // dequeue acts as a match forced at the head
  assign deq_hit  = (op == OP_DEQ);
  assign hit[0]   = deq_hit;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] upper_id;

    assign cell_ctrl[i].occupied = (CNT_W'(i) < count);
    assign cell_ctrl[i].at_tail  = (CNT_W'(i) == count);
    assign cell_ctrl[i].append   = append;
    assign cell_ctrl[i].collapse = collapse;

    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign upper_id = key;
    end else begin : g_mid
      assign upper_id = cell_id[i+1];
    end

    trfr_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[i]),
      .key      (key),
      .upper_id (upper_id),
      .hit_in   (hit[i]),
      .hit_out  (hit[i+1]),
      .id       (cell_id[i])
    );
  end

  always_comb begin
    count_next  = count;
    res_id_next = key;
    status_next = ST_MISS;
    case (op)
      OP_ENQ: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          count_next  = count + CNT_W'(1);
          status_next = ST_OK;
        end
      end
      OP_DEQ: begin
        if (!is_empty) begin
          res_id_next = cell_id[0];
          count_next  = count - CNT_W'(1);
          status_next = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (hit[QUEUE_DEPTH]) begin
          count_next  = count - CNT_W'(1);
          status_next = ST_OK;
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      res_id <= res_id_next;
      status <= status_next;
    end
  end

  assign m_tdata = {{(8 - ID_W){1'b0}}, res_id};
  assign m_tuser = status;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (s_fire && op == OP_ENQ && is_full) |=> (m_tuser == ST_FULL && $stable(count)))
    else $error("enqueue on full queue not flagged or count changed");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    (s_fire && op == OP_ENQ && !is_full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("enqueue did not advance count");

  a_deq_empty: assert property (@(posedge clk) disable iff (rst)
    (s_fire && op == OP_DEQ && is_empty) |=> (m_tuser == ST_MISS && count == '0))
    else $error("dequeue on empty queue misreported");

  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    (s_fire && op == OP_REMOVE) |=>
      ((m_tuser == ST_OK) == (count == $past(count) - CNT_W'(1))))
    else $error("remove status disagrees with count change");

endmodule

// File: bench/task_ready_fifo_with_remove_unit_tb.sv
// Self-checking testbench for the task ready queue with remove-by-identifier.
`timescale 1ns / 1ps

module task_ready_fifo_with_remove_unit_tb;
  import trfr_pkg::*;

  localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOW_LIMIT  = 10;
  localparam int DRAIN_WAIT  = 10;
  localparam logic [1:0] OP_NONE = 2'd3;  // undefined opcode, acts as a miss

  typedef struct packed {
    logic [ID_W-1:0] id;
    status_t         status;
  } queue_result_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;   // [4:0] task_id, [7:5] zero
  logic [1:0] s_tuser = '0;   // [1:0] opcode
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;        // [4:0] out_task_id, [7:5] zero
  logic [1:0] m_tuser;        // [1:0] status

  logic [ID_W-1:0] ready_ids[$];        // predicted queue contents, head first
  queue_result_t   pending_results[$];  // results owed by the block, oldest first
  int              mismatch_count = 0;
  int              cycle_count = 0;
  int              hold_cycles = 0;
  bit              tx_idle_en = 1'b1;
  bit              rx_idle_en = 1'b1;

  task_ready_fifo_with_remove_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one word to the queue state and return what the block must answer.
  function automatic queue_result_t apply_word(input logic [1:0] op, input logic [ID_W-1:0] id);
    queue_result_t res;
    int            hit;
    res.id     = id;
    res.status = ST_MISS;
    hit        = -1;
    case (op)
      OP_ENQ: begin
        if (ready_ids.size() >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ready_ids.push_back(id);
          res.status = ST_OK;
        end
      end
      OP_DEQ: begin
        if (ready_ids.size() != 0) begin
          res.id     = ready_ids.pop_front();
          res.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < ready_ids.size(); i++) begin
          if (hit < 0 && ready_ids[i] == id) hit = i;
        end
        if (hit >= 0) begin
          ready_ids.delete(hit);
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [ID_W-1:0] id);
    if (tx_idle_en) begin
      while ($urandom_range(99) < 12) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, id};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_word(op, id));
  endtask

  // Drop valid and hold until every owed result is back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_word(input int enq_weight);
    int              r;
    logic [1:0]      op;
    logic [ID_W-1:0] id;
    r  = $urandom_range(99);
    id = ID_W'($urandom_range(31));
    if (r < 3) begin
      op = OP_NONE;
    end else if (r < 3 + enq_weight) begin
      op = OP_ENQ;
    end else if (r < 3 + enq_weight + (97 - enq_weight) / 2) begin
      op = OP_DEQ;
    end else begin
      op = OP_REMOVE;
      // mostly aim at an identifier that is present, sometimes miss
      if (ready_ids.size() != 0 && $urandom_range(3) != 0)
        id = ready_ids[$urandom_range(ready_ids.size() - 1)];
    end
    send_word(op, id);
  endtask

  task automatic test_directed();
    send_word(OP_DEQ, 5'd31);     // dequeue on empty
    send_word(OP_REMOVE, 5'd0);   // remove on empty
    send_word(OP_NONE, 5'd31);
    send_word(OP_ENQ, 5'd0);
    send_word(OP_ENQ, 5'd31);
    send_word(OP_ENQ, 5'd31);     // duplicate
    send_word(OP_REMOVE, 5'd31);  // first of two matches
    send_word(OP_DEQ, 5'd10);
    send_word(OP_REMOVE, 5'd5);   // no match
    send_word(OP_REMOVE, 5'd31);  // single entry, also the tail
    send_word(OP_DEQ, 5'd0);
    send_word(OP_ENQ, 5'd7);
    send_word(OP_ENQ, 5'd8);
    send_word(OP_REMOVE, 5'd8);   // tail moves back
    send_word(OP_ENQ, 5'd9);      // must land after 7
    send_word(OP_DEQ, 5'd21);
    send_word(OP_DEQ, 5'd0);
    send_word(OP_DEQ, 5'd0);
    send_word(OP_NONE, 5'd0);
    send_word(OP_NONE, 5'd21);
  endtask

  task automatic test_full_queue();
    int k;
    k = 0;
    while (ready_ids.size() < QUEUE_DEPTH) begin
      send_word(OP_ENQ, 5'(k));
      k++;
    end
    send_word(OP_ENQ, 5'd31);     // overflow
    send_word(OP_ENQ, 5'd0);
    send_word(OP_REMOVE, ready_ids[$]);
    send_word(OP_ENQ, 5'd17);
    send_word(OP_REMOVE, ready_ids[0]);
    send_word(OP_REMOVE, ready_ids[QUEUE_DEPTH / 2]);
    while (ready_ids.size() != 0) send_word(OP_DEQ, 5'($urandom_range(31)));
    send_word(OP_DEQ, 5'd31);
  endtask

  task automatic test_mixed_traffic(input int n_words, input int enq_weight);
    for (int i = 0; i < n_words; i++) send_random_word(enq_weight);
  endtask

  // Stall the output for a long stretch while words keep arriving.
  task automatic test_output_stall(input int stall, input int n_words);
    hold_cycles = stall;
    for (int i = 0; i < n_words; i++) send_random_word(55);
  endtask

  task automatic test_steady_stream(input int n_words);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < n_words; i++) send_random_word(i % 200 < 100 ? 60 : 30);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready    <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_tready <= !(rx_idle_en && $urandom_range(99) < 12);
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("unexpected word: tdata=%h tuser=%0d", m_tdata, m_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== {3'b000, want.id} || m_tuser !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("word mismatch: id exp %0d got %0d, status exp %0d got %0d",
                     want.id, m_tdata, want.status, m_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_mixed_traffic(500, 60);
    test_output_stall(400, 60);
    drain_results();
    test_mixed_traffic(400, 30);
    test_steady_stream(400);
    test_output_stall(250, 40);
    test_mixed_traffic(500, 47);
    drain_results();
    test_mixed_traffic(100, 60);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
